>>> hdl/tgq_pkg.sv
// Package with constants, item types and state codes of the team grouped queue.
package tgq_pkg;

    localparam int ELEMENT_IDS = 1024;
    localparam int TEAMS       = 16;
    localparam int QUEUE_DEPTH = 256;

    localparam int ID_W   = $clog2(ELEMENT_IDS);
    localparam int TEAM_W = $clog2(TEAMS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_ENQUEUE = 2'd1,
        KIND_DEQUEUE = 2'd2,
        KIND_CLEAR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] element_id;
        logic [3:0] team_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] removed_element;
        logic [3:0] removed_team;
    } t_out_item;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_ENQ,
        S_DEQ,
        S_DONE
    } t_state;

endpackage

>>> hdl/team_grouped_queue_core.sv
// Top level of the team grouped queue: membership table, linked team lists and sequencer.

// An enqueue or a dequeue, once accepted in S_IDLE, passes through S_EXEC, which
// decodes it and issues the memory reads, S_ENQ or S_DEQ, which update the
// linked lists, and S_DONE, which hands the result to the output register. A
// load, a clear, an enqueue on a full queue and a dequeue on an empty queue skip
// the list update and go from S_EXEC straight to S_DONE. The output register
// waits for the consumer on its own. No next item is accepted meanwhile: the
// block holds in S_DONE, and keeps the input closed, until the register is free.
// The queue is held as a list of team groups in a small ring, with every group a
// singly linked list of slots in one element memory and one next-pointer memory;
// freed slots go on a free list. The membership table lives in a memory with one
// write port and one read port that is swept to team 0 after reset; no item is
// accepted during the sweep.
module team_grouped_queue_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tgq_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output tgq_pkg::t_out_item  o_item
);
    import tgq_pkg::*;

    t_state r_state, n_state;

    t_in_item  r_item;
    t_out_item r_res;
    t_out_item r_out;
    logic      r_out_valid;

    logic [ID_W-1:0] r_init;

    // Memories.
    logic [TEAM_W-1:0] memb_mem [ELEMENT_IDS];
    logic [9:0]        elem_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  next_mem [QUEUE_DEPTH];
    logic [TEAM_W-1:0] r_mteam;
    logic [9:0]        r_erd;
    logic [PTR_W-1:0]  r_nrd;

    // Queue bookkeeping.
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_fresh;
    logic [PTR_W-1:0]  r_free_head;
    logic [TEAM_W-1:0] r_grp [TEAMS];
    logic [TEAM_W-1:0] r_grp_head;
    logic [TEAM_W-1:0] r_grp_tail;
    logic [PTR_W-1:0]  r_team_head [TEAMS];
    logic [PTR_W-1:0]  r_team_tail [TEAMS];
    logic [LEN_W-1:0]  r_count [TEAMS];

    logic              accept;
    logic              out_load;
    logic [ID_W-1:0]   item_idx;
    logic [TEAM_W-1:0] head_team;
    logic [PTR_W-1:0]  head_slot;
    logic [PTR_W-1:0]  node_rd_addr;
    logic              use_free;
    logic [PTR_W-1:0]  new_slot;
    logic              memb_we;
    logic [ID_W-1:0]   memb_wa;
    logic [TEAM_W-1:0] memb_wd;
    logic              next_we;
    logic [PTR_W-1:0]  next_wa;
    logic [PTR_W-1:0]  next_wd;
    logic              elem_we;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign item_idx  = r_item.element_id[ID_W-1:0];
    assign head_team = r_grp[r_grp_head];
    assign head_slot = r_team_head[head_team];
    assign use_free  = (r_fresh > r_len);
    assign new_slot  = use_free ? r_free_head : r_fresh[PTR_W-1:0];

    // A dequeue reads the head slot; an enqueue reads the link of the free-list head.
    assign node_rd_addr = (t_kind'(r_item.kind) == KIND_DEQUEUE) ? head_slot : r_free_head;

    always_comb begin
        memb_we = 1'b0;
        memb_wa = item_idx;
        memb_wd = r_item.team_id[TEAM_W-1:0];
        next_we = 1'b0;
        next_wa = r_free_head;
        next_wd = new_slot;
        elem_we = 1'b0;
        case (r_state)
            S_INIT: begin
                memb_we = 1'b1;
                memb_wa = r_init;
                memb_wd = '0;
            end
            S_EXEC: begin
                memb_we = (t_kind'(r_item.kind) == KIND_LOAD);
            end
            S_ENQ: begin
                elem_we = 1'b1;
                next_we = (r_count[r_mteam] != '0);
                next_wa = r_team_tail[r_mteam];
                next_wd = new_slot;
            end
            S_DEQ: begin
                next_we = 1'b1;
                next_wa = head_slot;
                next_wd = r_free_head;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (memb_we) begin
            memb_mem[memb_wa] <= memb_wd;
        end
        r_mteam <= memb_mem[item_idx];
    end

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            elem_mem[new_slot] <= r_item.element_id;
        end
        r_erd <= elem_mem[node_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        r_nrd <= next_mem[node_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_init == ID_W'(ELEMENT_IDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (t_kind'(r_item.kind))
                    KIND_ENQUEUE: n_state = (r_len == LEN_W'(QUEUE_DEPTH)) ? S_DONE : S_ENQ;
                    KIND_DEQUEUE: n_state = (r_len == '0) ? S_DONE : S_DEQ;
                    default:      n_state = S_DONE;
                endcase
            end
            S_ENQ:  n_state = S_DONE;
            S_DEQ:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // Control registers of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= '0;
            r_len       <= '0;
            r_fresh     <= '0;
            r_grp_head  <= '0;
            r_grp_tail  <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < TEAMS; t++) begin
                r_count[t] <= '0;
            end
        end else begin
            if (r_state == S_INIT) begin
                r_init <= r_init + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_EXEC: begin
                    if (t_kind'(r_item.kind) == KIND_CLEAR) begin
                        r_len      <= '0;
                        r_fresh    <= '0;
                        r_grp_head <= '0;
                        r_grp_tail <= '0;
                        for (int t = 0; t < TEAMS; t++) begin
                            r_count[t] <= '0;
                        end
                    end
                end
                S_ENQ: begin
                    r_len            <= r_len + 1'b1;
                    r_count[r_mteam] <= r_count[r_mteam] + 1'b1;
                    if (!use_free) begin
                        r_fresh <= r_fresh + 1'b1;
                    end
                    if (r_count[r_mteam] == '0) begin
                        r_grp_tail <= r_grp_tail + 1'b1;
                    end
                end
                S_DEQ: begin
                    r_len              <= r_len - 1'b1;
                    r_count[head_team] <= r_count[head_team] - 1'b1;
                    // The group leaves the ring when its last member goes.
                    if (r_count[head_team] == LEN_W'(1)) begin
                        r_grp_head <= r_grp_head + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers: item, result, list pointers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (out_load) begin
            r_out <= r_res;
        end
        case (r_state)
            S_EXEC: begin
                r_res.removed_element <= '0;
                r_res.removed_team    <= '0;
                if (t_kind'(r_item.kind) == KIND_ENQUEUE && r_len == LEN_W'(QUEUE_DEPTH)) begin
                    r_res.status <= STATUS_FULL;
                end else if (t_kind'(r_item.kind) == KIND_DEQUEUE && r_len == '0) begin
                    r_res.status <= STATUS_EMPTY;
                end else begin
                    r_res.status <= STATUS_OK;
                end
            end
            S_ENQ: begin
                r_team_tail[r_mteam] <= new_slot;
                if (r_count[r_mteam] == '0) begin
                    r_team_head[r_mteam] <= new_slot;
                    r_grp[r_grp_tail]    <= r_mteam;
                end
                if (use_free) begin
                    r_free_head <= r_nrd;
                end
            end
            S_DEQ: begin
                r_res.removed_element   <= r_erd;
                r_res.removed_team      <= 4'(head_team);
                r_team_head[head_team]  <= r_nrd;
                r_free_head             <= head_slot;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> dv/team_grouped_queue_core_test.sv
// Self-checking testbench of the team grouped queue core with its own queue predictor.
module team_grouped_queue_core_test;
    import tgq_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int ID_POOL = 32;

    // One slot of the predicted queue: the element and the team it was queued under.
    typedef struct {
        logic [ID_W-1:0]   element;
        logic [TEAM_W-1:0] team;
    } t_queued_slot;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    team_grouped_queue_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // Predictor state.
    logic [TEAM_W-1:0] team_of_id [ELEMENT_IDS];
    int unsigned       members_per_team [TEAMS];
    t_queued_slot      team_line [$];
    t_out_item         pending_outcomes [$];

    int mismatch_count = 0;
    int burst_left = 0;
    bit long_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[team_grouped_queue_core] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Applies one accepted item to the predicted state and returns its outcome.
    function automatic t_out_item queue_outcome(input t_in_item req);
        t_out_item         res;
        t_queued_slot      slot;
        logic [TEAM_W-1:0] team;
        int                pos;
        bit                found;
        res = '0;
        case (req.kind)
            KIND_LOAD: begin
                team_of_id[req.element_id] = req.team_id;
            end
            KIND_ENQUEUE: begin
                if (team_line.size() >= QUEUE_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    team = team_of_id[req.element_id];
                    pos = team_line.size();
                    found = 1'b0;
                    // Go behind the first run of members of this team, if the team is queued.
                    if (members_per_team[team] != 0) begin
                        for (int k = 0; k < team_line.size() && !found; k++) begin
                            if (team_line[k].team == team) begin
                                found = 1'b1;
                                pos = k;
                                while (pos < team_line.size() && team_line[pos].team == team)
                                    pos++;
                            end
                        end
                    end
                    slot.element = req.element_id;
                    slot.team = team;
                    // An index equal to the size appends at the tail.
                    team_line.insert(pos, slot);
                    members_per_team[team]++;
                end
            end
            KIND_DEQUEUE: begin
                if (team_line.size() == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    slot = team_line[0];
                    team_line.delete(0);
                    res.removed_element = slot.element;
                    res.removed_team = slot.team;
                    if (members_per_team[slot.team] > 0)
                        members_per_team[slot.team]--;
                end
            end
            default: begin
                team_line.delete();
                foreach (members_per_team[t])
                    members_per_team[t] = 0;
            end
        endcase
        return res;
    endfunction

    // Sends one item in the current burst, opening a new burst after a random gap.
    task automatic send_item(input t_in_item req);
        int        gap;
        t_out_item outcome;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item  <= req;
        do @(posedge i_clk); while (!o_ready);
        outcome = queue_outcome(req);
        pending_outcomes.insert(pending_outcomes.size(), outcome);
    endtask

    // The sender stops until every outcome it is owed has come back.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input t_kind kind, input logic [ID_W-1:0] id,
                                           input logic [TEAM_W-1:0] team);
        t_in_item req;
        req.kind = kind;
        req.element_id = id;
        req.team_id = team;
        return req;
    endfunction

    // Ids mostly come from a small pool so that loads and grouping interact.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7)
            return ID_W'($urandom_range(0, ID_POOL - 1));
        return ID_W'($urandom);
    endfunction

    function automatic t_in_item random_request(input int enq_pct, input int deq_pct,
                                                input int clr_pct);
        t_in_item req;
        int       roll;
        roll = $urandom_range(0, 99);
        req.element_id = pick_id();
        req.team_id = ($urandom_range(0, 9) < 7) ? TEAM_W'($urandom_range(0, 5))
                                                 : TEAM_W'($urandom);
        if (roll < enq_pct)
            req.kind = KIND_ENQUEUE;
        else if (roll < enq_pct + deq_pct)
            req.kind = KIND_DEQUEUE;
        else if (roll < enq_pct + deq_pct + clr_pct)
            req.kind = KIND_CLEAR;
        else
            req.kind = KIND_LOAD;
        return req;
    endfunction

    task automatic test_directed();
        send_item(make_item(KIND_DEQUEUE, 10'h3FF, 4'hF));
        send_item(make_item(KIND_CLEAR, 10'h2AA, 4'h5));
        // An id that was never loaded belongs to team 0.
        send_item(make_item(KIND_ENQUEUE, 10'd5, 4'hA));
        send_item(make_item(KIND_LOAD, 10'd0, 4'd15));
        send_item(make_item(KIND_LOAD, 10'd1023, 4'd15));
        send_item(make_item(KIND_LOAD, 10'd512, 4'd7));
        send_item(make_item(KIND_LOAD, 10'd3, 4'd7));
        send_item(make_item(KIND_ENQUEUE, 10'd0, 4'd0));
        send_item(make_item(KIND_ENQUEUE, 10'd512, 4'd0));
        send_item(make_item(KIND_ENQUEUE, 10'd1023, 4'd0));
        send_item(make_item(KIND_ENQUEUE, 10'd3, 4'd0));
        send_item(make_item(KIND_ENQUEUE, 10'd9, 4'd0));
        // Reloading a queued element must not change the team reported on removal.
        send_item(make_item(KIND_LOAD, 10'd0, 4'd3));
        repeat (6) send_item(make_item(KIND_DEQUEUE, 10'h155, 4'h9));
        send_item(make_item(KIND_DEQUEUE, 10'd0, 4'd0));
        send_item(make_item(KIND_ENQUEUE, 10'd512, 4'd0));
        send_item(make_item(KIND_ENQUEUE, 10'd0, 4'd0));
        send_item(make_item(KIND_CLEAR, 10'd0, 4'd0));
        send_item(make_item(KIND_DEQUEUE, 10'd0, 4'd0));
        // After a clear the counts are zero, so the team goes to the tail again.
        send_item(make_item(KIND_ENQUEUE, 10'd3, 4'd0));
        send_item(make_item(KIND_DEQUEUE, 10'd0, 4'd0));
        wait_for_drain();
    endtask

    task automatic test_full_queue();
        t_in_item req;
        send_item(make_item(KIND_CLEAR, 10'd0, 4'd0));
        repeat (QUEUE_DEPTH + 3) begin
            req = random_request(100, 0, 0);
            send_item(req);
        end
        send_item(make_item(KIND_DEQUEUE, 10'd0, 4'd0));
        send_item(make_item(KIND_ENQUEUE, 10'd1023, 4'd0));
        send_item(make_item(KIND_ENQUEUE, 10'd1, 4'd0));
        repeat (QUEUE_DEPTH + 1) send_item(make_item(KIND_DEQUEUE, ID_W'($urandom), 4'd0));
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        repeat (60) send_item(random_request(50, 30, 2));
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 1250; n++) begin
            send_item(random_request(42, 36, 3));
            if (n == 400 || n == 900)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    // Receiver: alternating stretches of steady acceptance and stalls of varying density.
    initial begin
        int mode;
        int seg;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                seg = $urandom_range(10, 60);
                repeat (seg) begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= ($urandom_range(0, 3) != 0);
                        2: i_ready <= 1'($urandom_range(0, 1));
                        default: i_ready <= ($urandom_range(0, 7) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Outcome checker.
    initial begin
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("unexpected outcome %p", o_item));
                end else begin
                    want = pending_outcomes[0];
                    pending_outcomes.delete(0);
                    if (o_item.status != want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_item.status, want.status));
                    if (o_item.removed_element != want.removed_element)
                        report_mismatch($sformatf("removed_element %0d, want %0d",
                                                  o_item.removed_element,
                                                  want.removed_element));
                    if (o_item.removed_team != want.removed_team)
                        report_mismatch($sformatf("removed_team %0d, want %0d",
                                                  o_item.removed_team, want.removed_team));
                end
            end
        end
    end

    initial begin
        foreach (team_of_id[i])
            team_of_id[i] = '0;
        foreach (members_per_team[t])
            members_per_team[t] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_queue();
        test_backpressure();
        test_random_mix();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("[team_grouped_queue_core] OK");
        else
            $display("[team_grouped_queue_core] ERROR");
        $finish;
    end

endmodule
